@@ rtl/gbk_pkg.sv @@
// Shared widths and request structures for the glyph row expander.
// Used by address unit, font store, row sequencer, top level; depends on nothing.
package gbk_pkg;

   localparam int STORE_ADDR_W = 20;
   localparam int BYTE_W       = 8;
   localparam int ROW_IDX_W    = 4;
   localparam int PIX_W        = 16;

   typedef struct packed {
      logic                    en;
      logic [STORE_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]       data;
   } font_wr_req_type;

   typedef struct packed {
      logic                    en;
      logic [STORE_ADDR_W-1:0] addr;
   } font_rd_req_type;

endpackage

@@ rtl/gbk_bitmap_glyph_row_expander.sv @@
// Top level of the glyph row expander: stream ports, glyph size register and wiring
// of the address unit, font store and row sequencer. Depends on gbk_pkg and those modules.
//
//   port group | direction | transfer carries
//   req_*      | in        | tuser: func; tdata: store_address, store_byte, first_byte, second_byte
//   rsp_*      | out       | tdata: row_index, row_pixels; tlast: last_row
//   csr_*      | in        | font_size_select, written whenever csr_wr_en is high
//
// A load transfer writes the font store in its accept cycle; the next transfer can follow at once.
// A render transfer holds the input closed until the sequencer is idle again. When rows are
// taken at once, that time goes to address work, one store read per glyph byte (32 or 18),
// a wait per 12-point row pair while its even row is still held, and a drain state.
// The single byte-wide read port of the font store paces the reads.
// A row that completes while the previous row is still held stalls the byte reads.
// Reset is synchronous and clears control state only; the font store is not cleared.
module gbk_bitmap_glyph_row_expander #(
   parameter int FONT_BYTES = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // store_address[19:0], store_byte[27:20],
                                    // first_byte[35:28], second_byte[43:36], zero fill
   input  logic [0:0]  req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // row_index[3:0], row_pixels[19:4], zero fill
   output logic        rsp_tlast,   // last_row
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // font_size_select
);
   import gbk_pkg::*;

   logic                    size16_ff;
   logic                    req_fire;
   logic                    start;
   logic                    busy;
   logic                    base_valid;
   logic [STORE_ADDR_W-1:0] base;
   font_wr_req_type         wr;
   font_rd_req_type         rd;
   logic [BYTE_W-1:0]       rd_data;
   logic [ROW_IDX_W-1:0]    out_row;
   logic [PIX_W-1:0]        out_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         size16_ff <= 1'b1;
      end else if (csr_wr_en) begin
         size16_ff <= csr_wr_data;
      end
   end

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign start      = req_fire && req_tuser[0];

   assign wr.en   = req_fire && !req_tuser[0];
   assign wr.addr = req_tdata[19:0];
   assign wr.data = req_tdata[27:20];

   gbk_glyph_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .size16      (size16_ff),
      .first_byte  (req_tdata[35:28]),
      .second_byte (req_tdata[43:36]),
      .base_valid  (base_valid),
      .base        (base)
   );

   gbk_font_mem #(
      .FONT_BYTES (FONT_BYTES)
   ) u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   gbk_row_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .size16     (size16_ff),
      .base_valid (base_valid),
      .base       (base),
      .rsp_tready (rsp_tready),
      .rd         (rd),
      .rd_data    (rd_data),
      .out_valid  (rsp_tvalid),
      .out_row    (out_row),
      .out_pix    (out_pix),
      .out_last   (rsp_tlast),
      .busy       (busy)
   );

   assign rsp_tdata = {4'b0, out_pix, out_row};

endmodule

@@ rtl/gbk_glyph_addr.sv @@
// Two-stage unit that maps a character code pair to the byte address of its glyph.
// Stage one classifies the code and forms the glyph index, stage two scales it by glyph size.
// Depends on gbk_pkg.
module gbk_glyph_addr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             size16,
   input  logic [gbk_pkg::BYTE_W-1:0]       first_byte,
   input  logic [gbk_pkg::BYTE_W-1:0]       second_byte,
   output logic                             base_valid,
   output logic [gbk_pkg::STORE_ADDR_W-1:0] base
);
   import gbk_pkg::*;

   localparam int IDX_W = 15;

   localparam logic [7:0] ASCII_FIRST    = 8'h20;
   localparam logic [7:0] ASCII_LAST     = 8'h7F;
   localparam logic [7:0] LEAD_FIRST     = 8'h81;
   localparam logic [7:0] LEAD_LAST      = 8'hFE;
   localparam logic [7:0] TRAIL_LO_FIRST = 8'h40;
   localparam logic [7:0] TRAIL_LO_LAST  = 8'h7E;
   localparam logic [7:0] TRAIL_HI_FIRST = 8'h80;
   localparam logic [7:0] TRAIL_HI_LAST  = 8'hFE;
   localparam logic [7:0] SUB_LEAD       = 8'hA1;
   localparam logic [7:0] SUB_TRAIL      = 8'hF5;
   localparam int         GBK_ROW_SPAN   = 190;
   localparam int         ASCII_GLYPHS   = 96;
   localparam int         TRAIL_LO_COUNT = 63;

   logic             is_ascii;
   logic             pair_ok;
   logic [7:0]       lead;
   logic [7:0]       trail;
   logic [6:0]       lead_off;
   logic [7:0]       trail_off;
   logic [IDX_W-1:0] idx_in;
   logic [IDX_W-1:0] idx_ff;
   logic             idx_valid_ff;
   logic [STORE_ADDR_W-1:0] base_in;
   logic [STORE_ADDR_W-1:0] base_ff;
   logic             base_valid_ff;

   always_comb begin
      is_ascii = (first_byte >= ASCII_FIRST) && (first_byte <= ASCII_LAST);
      pair_ok  = (first_byte >= LEAD_FIRST) && (first_byte <= LEAD_LAST) &&
                 (((second_byte >= TRAIL_LO_FIRST) && (second_byte <= TRAIL_LO_LAST)) ||
                  ((second_byte >= TRAIL_HI_FIRST) && (second_byte <= TRAIL_HI_LAST)));
      // Any pair that is neither ASCII nor valid GBK renders as the substitute glyph.
      lead     = pair_ok ? first_byte  : SUB_LEAD;
      trail    = pair_ok ? second_byte : SUB_TRAIL;
      lead_off = 7'(lead - LEAD_FIRST);
      if (trail <= TRAIL_LO_LAST) begin
         trail_off = 8'(trail - TRAIL_LO_FIRST);
      end else begin
         trail_off = 8'(trail - TRAIL_HI_FIRST) + 8'(TRAIL_LO_COUNT);
      end
      if (is_ascii) begin
         idx_in = IDX_W'(first_byte - ASCII_FIRST);
      end else begin
         idx_in = IDX_W'(lead_off) * IDX_W'(GBK_ROW_SPAN) + IDX_W'(ASCII_GLYPHS) +
                  IDX_W'(trail_off);
      end
      // 32 bytes per glyph at 16 points, 18 (16 + 2) at 12 points.
      if (size16) begin
         base_in = STORE_ADDR_W'({idx_ff, 5'b0});
      end else begin
         base_in = STORE_ADDR_W'({1'b0, idx_ff, 4'b0}) + STORE_ADDR_W'({4'b0, idx_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_valid_ff  <= 1'b0;
         base_valid_ff <= 1'b0;
      end else begin
         idx_valid_ff  <= start;
         base_valid_ff <= idx_valid_ff;
      end
      if (start) begin
         idx_ff <= idx_in;
      end
      if (idx_valid_ff) begin
         base_ff <= base_in;
      end
   end

   assign base_valid = base_valid_ff;
   assign base       = base_ff;

endmodule

@@ rtl/gbk_font_mem.sv @@
// Byte-wide font store: one write port and one read port with registered read data.
// Depends on gbk_pkg for the request structures.
module gbk_font_mem #(
   parameter int FONT_BYTES = 1048576
) (
   input  logic                         clock,
   input  gbk_pkg::font_wr_req_type     wr,
   input  gbk_pkg::font_rd_req_type     rd,
   output logic [gbk_pkg::BYTE_W-1:0]   rd_data
);
   import gbk_pkg::*;

   localparam int MEM_AW = $clog2(FONT_BYTES);
   localparam logic [STORE_ADDR_W:0] FONT_LIMIT = (STORE_ADDR_W+1)'(FONT_BYTES);

   logic [BYTE_W-1:0] font_mem_ff [FONT_BYTES];
   logic [BYTE_W-1:0] rd_byte_ff;
   logic              rd_oob_ff;
   logic              wr_in_range;
   logic              rd_in_range;

   assign wr_in_range = {1'b0, wr.addr} < FONT_LIMIT;
   assign rd_in_range = {1'b0, rd.addr} < FONT_LIMIT;

   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         font_mem_ff[wr.addr[MEM_AW-1:0]] <= wr.data;
      end
      if (rd.en) begin
         rd_byte_ff <= font_mem_ff[rd.addr[MEM_AW-1:0]];
         rd_oob_ff  <= !rd_in_range;
      end
   end

   // Bytes past the end of the store read as zero.
   assign rd_data = rd_oob_ff ? '0 : rd_byte_ff;

endmodule

@@ rtl/gbk_row_seq.sv @@
// Row sequencer: reads a glyph's bytes from the font store one per cycle unless a held row
// stalls them, builds pixel rows and holds each in the output register. Depends on gbk_pkg.
module gbk_row_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             size16,
   input  logic                             base_valid,
   input  logic [gbk_pkg::STORE_ADDR_W-1:0] base,
   input  logic                             rsp_tready,
   output gbk_pkg::font_rd_req_type         rd,
   input  logic [gbk_pkg::BYTE_W-1:0]       rd_data,
   output logic                             out_valid,
   output logic [gbk_pkg::ROW_IDX_W-1:0]    out_row,
   output logic [gbk_pkg::PIX_W-1:0]        out_pix,
   output logic                             out_last,
   output logic                             busy
);
   import gbk_pkg::*;

   localparam int BYTES16 = 32;
   localparam int BYTES12 = 18;
   localparam int ROWS16  = 16;
   localparam int ROWS12  = 12;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ADDR  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_DRAIN = 4'b1000
   } seq_state_type;

   typedef enum logic [1:0] {
      ROLE_KEEP        = 2'd0,
      ROLE_EMIT16      = 2'd1,
      ROLE_EMIT12_EVEN = 2'd2,
      ROLE_EMIT12_ODD  = 2'd3
   } byte_role_type;

   seq_state_type           state_ff, state_in;
   logic [STORE_ADDR_W-1:0] addr_ff;
   logic [4:0]              cnt_ff;
   logic [1:0]              phase_ff;
   logic                    ret_valid_ff;
   byte_role_type           ret_role_ff;
   byte_role_type           issue_role;
   logic [BYTE_W-1:0]       b0_ff;
   logic [ROW_IDX_W-1:0]    row_ff;
   logic                    out_valid_ff;
   logic [ROW_IDX_W-1:0]    out_row_ff;
   logic [PIX_W-1:0]        out_pix_ff;
   logic                    out_last_ff;
   logic                    ret_emit;
   logic                    slot_busy_next;
   logic                    issue;
   logic                    last_byte;
   logic                    last_row_now;
   logic [PIX_W-1:0]        pix_in;

   always_comb begin
      if (size16) begin
         issue_role = cnt_ff[0] ? ROLE_EMIT16 : ROLE_KEEP;
      end else if (phase_ff == 2'd0) begin
         issue_role = ROLE_KEEP;
      end else if (phase_ff == 2'd1) begin
         issue_role = ROLE_EMIT12_EVEN;
      end else begin
         issue_role = ROLE_EMIT12_ODD;
      end

      ret_emit = ret_valid_ff && (ret_role_ff != ROLE_KEEP);
      // A byte that completes a row is read only if the output register is free when it lands.
      slot_busy_next = (out_valid_ff && !rsp_tready) || ret_emit;
      issue = (state_ff == ST_READ) && ((issue_role == ROLE_KEEP) || !slot_busy_next);

      last_byte    = cnt_ff == (size16 ? 5'(BYTES16 - 1) : 5'(BYTES12 - 1));
      last_row_now = row_ff == (size16 ? ROW_IDX_W'(ROWS16 - 1) : ROW_IDX_W'(ROWS12 - 1));

      // The first byte of a 12-point row pair stays in b0_ff for both rows of the pair.
      case (ret_role_ff)
         ROLE_EMIT16:      pix_in = {rd_data, b0_ff};
         ROLE_EMIT12_EVEN: pix_in = {rd_data, b0_ff[7:4], 4'b0};
         ROLE_EMIT12_ODD:  pix_in = {b0_ff[3:0], rd_data, 4'b0};
         default:          pix_in = '0;
      endcase

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_ADDR;
         end
         ST_ADDR: begin
            if (base_valid) state_in = ST_READ;
         end
         ST_READ: begin
            if (issue && last_byte) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_valid_ff <= issue;
         if (ret_emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end

      if ((state_ff == ST_ADDR) && base_valid) begin
         addr_ff  <= base;
         cnt_ff   <= '0;
         phase_ff <= '0;
         row_ff   <= '0;
      end else begin
         if (issue) begin
            addr_ff  <= addr_ff + 1'b1;
            cnt_ff   <= cnt_ff + 1'b1;
            phase_ff <= (phase_ff == 2'd2) ? 2'd0 : phase_ff + 1'b1;
         end
         if (ret_emit) begin
            row_ff <= row_ff + 1'b1;
         end
      end

      if (issue) begin
         ret_role_ff <= issue_role;
      end
      if (ret_valid_ff && (ret_role_ff == ROLE_KEEP)) begin
         b0_ff <= rd_data;
      end
      if (ret_emit) begin
         out_row_ff  <= row_ff;
         out_pix_ff  <= pix_in;
         out_last_ff <= last_row_now;
      end
   end

   assign rd.en     = issue;
   assign rd.addr   = addr_ff;
   assign out_valid = out_valid_ff;
   assign out_row   = out_row_ff;
   assign out_pix   = out_pix_ff;
   assign out_last  = out_last_ff;
   assign busy      = state_ff != ST_IDLE;

endmodule

@@ rtl/gbk_port_checker.sv @@
// Port-level checks for the glyph row expander, attached by the bind below.
// Sees only the top level's ports; depends on nothing else.
module gbk_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A held row keeps its contents until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp row changed while stalled");

   a_last_row_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[3:0] == 4'd11) || (rsp_tdata[3:0] == 4'd15))
      else $error("last row flagged at a row that ends no glyph");

   a_row15_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:0] == 4'd15) |-> rsp_tlast)
      else $error("row 15 not flagged as last");

   // A render transfer occupies the block, so the input closes right after it.
   a_render_closes_input: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("input still open after a render transfer");

   a_reset_empties_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("row offered right after reset");

endmodule

bind gbk_bitmap_glyph_row_expander gbk_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
